@@ rtl/sc2a_pkg.sv @@
// Shared types, scancode constants and US layout tables for the scancode translator.
package sc2a_pkg;

    // Default character FIFO depth (holds one entry fewer than this)
    localparam int FIFO_DEPTH_DEF = 128;

    // Character width and layout table size
    localparam int CHAR_W     = 7;
    localparam int LAYOUT_IDX = 6;
    localparam int LAYOUT_N   = 64;

    // Set-1 scancodes with special meaning
    localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
    localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
    localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
    localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;
    localparam int         SC_BREAK_BIT    = 7;

    // Request kinds carried in tuser
    localparam logic MODE_SCANCODE = 1'b0;
    localparam logic MODE_READ     = 1'b1;

    // Command handed from the front end to the back end
    typedef struct packed {
        logic              is_read;
        logic [CHAR_W-1:0] ch;
    } sc2a_cmd_t;

    // Unshifted US layout, zero past the end of the layout
    localparam logic [CHAR_W-1:0] PLAIN_MAP [LAYOUT_N] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    // Shifted US layout, zero past the end of the layout
    localparam logic [CHAR_W-1:0] UPPER_MAP [LAYOUT_N] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

endpackage

@@ rtl/sc2a_front.sv @@
// Front end: accepts requests, tracks shift and translates make codes to commands.
module sc2a_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] scancode
    input  logic                 s_axis_tuser,   // [0] mode
    output logic                 cmd_valid,
    input  logic                 cmd_ready,
    output sc2a_pkg::sc2a_cmd_t  cmd
);

    logic                           shift_reg;
    logic                           shift_next;
    logic                           accept;
    logic                           is_read;
    logic                           is_shift_make;
    logic                           is_shift_break;
    logic                           in_layout;
    logic [sc2a_pkg::CHAR_W-1:0]    mapped;
    logic                           produce;

    // Classify the incoming request
    always_comb begin
        is_read        = (s_axis_tuser == sc2a_pkg::MODE_READ);
        is_shift_make  = s_axis_tdata inside {sc2a_pkg::SC_LSHIFT_MAKE,
                                              sc2a_pkg::SC_RSHIFT_MAKE};
        is_shift_break = s_axis_tdata inside {sc2a_pkg::SC_LSHIFT_BREAK,
                                              sc2a_pkg::SC_RSHIFT_BREAK};
        in_layout      = (s_axis_tdata[7:sc2a_pkg::LAYOUT_IDX] == '0);
        mapped         = shift_reg ?
                         sc2a_pkg::UPPER_MAP[s_axis_tdata[sc2a_pkg::LAYOUT_IDX-1:0]] :
                         sc2a_pkg::PLAIN_MAP[s_axis_tdata[sc2a_pkg::LAYOUT_IDX-1:0]];
        produce        = is_read || (!s_axis_tdata[sc2a_pkg::SC_BREAK_BIT] && in_layout &&
                         !is_shift_make && (mapped != '0));
    end

    // Stall on a full command queue; drop requests that give no command
    assign s_axis_tready = cmd_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign cmd_valid     = s_axis_tvalid && produce;
    assign cmd.is_read   = is_read;
    assign cmd.ch        = is_read ? '0 : mapped;

    // Track the shift keys
    always_comb begin
        shift_next = shift_reg;
        if (accept && !is_read) begin
            if (is_shift_make) begin
                shift_next = 1'b1;
            end else if (is_shift_break) begin
                shift_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg <= 1'b0;
        end else begin
            shift_reg <= shift_next;
        end
    end

endmodule

@@ rtl/sc2a_cmd_queue.sv @@
// Two-entry command queue between the front end and the back end.
module sc2a_cmd_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  sc2a_pkg::sc2a_cmd_t  push_cmd,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output sc2a_pkg::sc2a_cmd_t  pop_cmd
);

    sc2a_pkg::sc2a_cmd_t slot_reg [2];
    logic                wr_idx_reg, wr_idx_next;
    logic                rd_idx_reg, rd_idx_next;
    logic [1:0]          cnt_reg, cnt_next;
    logic                push_fire;
    logic                pop_fire;

    assign push_ready = (cnt_reg != 2'd2);
    assign pop_valid  = (cnt_reg != 2'd0);
    assign pop_cmd    = slot_reg[rd_idx_reg];
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;

    // Advance indexes and occupancy
    always_comb begin
        wr_idx_next = push_fire ? ~wr_idx_reg : wr_idx_reg;
        rd_idx_next = pop_fire ? ~rd_idx_reg : rd_idx_reg;
        cnt_next    = cnt_reg;
        if (push_fire && !pop_fire) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop_fire && !push_fire) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg <= 1'b0;
            rd_idx_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store pushed commands
    always_ff @(posedge aclk) begin
        if (push_fire) begin
            slot_reg[wr_idx_reg] <= push_cmd;
        end
    end

endmodule

@@ rtl/sc2a_back.sv @@
// Back end: character ring FIFO, pops on read commands and the result register.
module sc2a_back #(
    parameter int FIFO_DEPTH = sc2a_pkg::FIFO_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  sc2a_pkg::sc2a_cmd_t  cmd,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,   // [6:0] char_code, [7] zero
    output logic                 m_axis_tuser    // [0] char_valid
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

    logic [sc2a_pkg::CHAR_W-1:0] mem [FIFO_DEPTH];

    logic [PTR_W-1:0]            wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]            rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]            wr_ptr_inc;
    logic [PTR_W-1:0]            rd_ptr_inc;
    logic                        pend_reg, pend_next;
    logic                        pend_hit_reg;
    logic [sc2a_pkg::CHAR_W-1:0] rdata_reg;
    logic                        out_valid_reg, out_valid_next;
    logic                        out_hit_reg;
    logic [sc2a_pkg::CHAR_W-1:0] out_char_reg;
    logic                        empty;
    logic                        full;
    logic                        move;
    logic                        pend_free;
    logic                        cmd_take;
    logic                        push_fire;
    logic                        read_fire;

    assign wr_ptr_inc = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
    assign empty      = (wr_ptr_reg == rd_ptr_reg);
    assign full       = (wr_ptr_inc == rd_ptr_reg);

    // Hand the pending read to the result register when it is free
    assign move      = pend_reg && (!out_valid_reg || m_axis_tready);
    assign pend_free = !pend_reg || move;
    assign cmd_take  = cmd_valid && (!cmd.is_read || pend_free);
    assign cmd_ready = !cmd.is_read || pend_free;
    assign push_fire = cmd_take && !cmd.is_read && !full;
    assign read_fire = cmd_take && cmd.is_read;

    // Next values of pointers and control
    always_comb begin
        wr_ptr_next    = push_fire ? wr_ptr_inc : wr_ptr_reg;
        rd_ptr_next    = (read_fire && !empty) ? rd_ptr_inc : rd_ptr_reg;
        pend_next      = read_fire ? 1'b1 : (move ? 1'b0 : pend_reg);
        out_valid_next = move ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Write characters and read the oldest one
    always_ff @(posedge aclk) begin
        if (push_fire) begin
            mem[wr_ptr_reg] <= cmd.ch;
        end
        if (read_fire) begin
            rdata_reg    <= mem[rd_ptr_reg];
            pend_hit_reg <= !empty;
        end
    end

    // Load the result register, zero the character on an empty read
    always_ff @(posedge aclk) begin
        if (move) begin
            out_hit_reg  <= pend_hit_reg;
            out_char_reg <= pend_hit_reg ? rdata_reg : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_hit_reg;
    assign m_axis_tdata  = {1'b0, out_char_reg};

endmodule

@@ rtl/scancode_to_ascii_fifo.sv @@
// Top level of the set-1 scancode to ASCII translator with character FIFO.
// Requests enter on the s_axis stream: tuser 0 carries a set-1 scancode in tdata,
// tuser 1 asks for one character. Shift make and break codes set and clear the
// shift state; other make codes with a character in the US layout land in a ring FIFO
// of FIFO_DEPTH entries that keeps FIFO_DEPTH-1 characters, dropping new ones when
// full. Each read returns one result on m_axis: tuser says whether a character was
// popped and tdata carries it, zero when the FIFO was empty. Scancodes return
// nothing. One request is taken per cycle when the output is not stalled; a read
// result passes through the command queue slot, the registered FIFO memory read
// and the result register before it shows on m_axis.
module scancode_to_ascii_fifo #(
    parameter int FIFO_DEPTH = sc2a_pkg::FIFO_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [7:0] scancode
    input  logic       s_axis_tuser,    // [0] mode
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,    // [6:0] char_code, [7] zero
    output logic       m_axis_tuser     // [0] char_valid
);

    logic                fq_valid;
    logic                fq_ready;
    sc2a_pkg::sc2a_cmd_t fq_cmd;
    logic                qb_valid;
    logic                qb_ready;
    sc2a_pkg::sc2a_cmd_t qb_cmd;

    // Accept and translate requests
    sc2a_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cmd_valid     (fq_valid),
        .cmd_ready     (fq_ready),
        .cmd           (fq_cmd)
    );

    // Decouple front and back
    sc2a_cmd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_cmd   (fq_cmd),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_cmd    (qb_cmd)
    );

    // Run commands against the character FIFO
    sc2a_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid     (qb_valid),
        .cmd_ready     (qb_ready),
        .cmd           (qb_cmd),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

@@ rtl/sc2a_checker.sv @@
// Port-level checks for the scancode translator and their binding to the top level.
module sc2a_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       s_axis_tuser,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tuser
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

    // An empty read gives a zero character
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 8'h00))
        else $error("empty read with nonzero character");

    // A popped character is nonzero 7-bit ASCII
    a_char_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser) |->
        (!m_axis_tdata[7] && (m_axis_tdata[6:0] != 7'h00)))
        else $error("popped character out of range");

    // No result is valid when reset is first released
    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> !m_axis_tvalid)
        else $error("result shown right after reset");

endmodule

bind scancode_to_ascii_fifo sc2a_checker u_sc2a_checker (.*);

@@ verif/tb_top.sv @@
// Self-checking testbench for the scancode to ASCII translator with character FIFO.
`timescale 1ns / 100ps

module tb_top;

    localparam int CHAR_SLOTS     = sc2a_pkg::FIFO_DEPTH_DEF - 1;
    localparam int KEY_COUNT      = 59;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int REPORT_LIMIT   = 10;

    // Unshifted and shifted US key layouts, zero where a key types nothing
    localparam logic [sc2a_pkg::CHAR_W-1:0] BASE_KEYS [KEY_COUNT] = '{
        7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
        7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
        7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
        7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
        7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
        7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
        7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00
    };
    localparam logic [sc2a_pkg::CHAR_W-1:0] SHIFTED_KEYS [KEY_COUNT] = '{
        7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
        7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
        7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
        7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
        7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
        7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
        7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
        7'h00, 7'h20, 7'h00
    };

    typedef struct packed {
        logic                        valid;
        logic [sc2a_pkg::CHAR_W-1:0] code;
    } char_result_t;

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;     // [7:0] scancode
    logic       s_axis_tuser  = 1'b0;      // [0] mode
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;              // [6:0] char_code, [7] zero
    logic       m_axis_tuser;              // [0] char_valid

    // Predicted block state and the queue of read results still to come
    logic [sc2a_pkg::CHAR_W-1:0] typed_chars [$];
    logic                        shift_down = 1'b0;
    char_result_t                pending_reads [$];

    int  fail_count      = 0;
    int  idle_cycles     = 0;
    int  hold_off_cycles = 0;
    bit  source_gaps_on  = 1'b1;
    bit  sink_stalls_on  = 1'b1;

    scancode_to_ascii_fifo #(
        .FIFO_DEPTH(sc2a_pkg::FIFO_DEPTH_DEF)
    ) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Hold reset low at the start, then release it
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
    end

    task automatic note_failure(input string what, input char_result_t want,
                                input logic got_valid, input logic [7:0] got_data);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("%0t: %s: expected valid=%0b code=0x%02h, got valid=%0b data=0x%02h",
                     $realtime, what, want.valid, want.code, got_valid, got_data);
        end
    endtask

    // Advance the predicted state by one accepted request
    task automatic predict_request(input logic mode, input logic [7:0] code);
        char_result_t                res;
        logic [sc2a_pkg::CHAR_W-1:0] ch;
        if (mode == sc2a_pkg::MODE_READ) begin
            if (typed_chars.size() == 0) begin
                res = '{valid: 1'b0, code: '0};
            end else begin
                res = '{valid: 1'b1, code: typed_chars.pop_front()};
            end
            pending_reads.push_back(res);
        end else if (code inside {sc2a_pkg::SC_LSHIFT_MAKE, sc2a_pkg::SC_RSHIFT_MAKE}) begin
            shift_down = 1'b1;
        end else if (code inside {sc2a_pkg::SC_LSHIFT_BREAK, sc2a_pkg::SC_RSHIFT_BREAK}) begin
            shift_down = 1'b0;
        end else if (!code[sc2a_pkg::SC_BREAK_BIT] && code < KEY_COUNT) begin
            ch = shift_down ? SHIFTED_KEYS[code] : BASE_KEYS[code];
            // drop unmapped keys and characters that find the FIFO full
            if (ch != '0 && typed_chars.size() < CHAR_SLOTS) begin
                typed_chars.push_back(ch);
            end
        end
    endtask

    // Offer one request, wait for its handshake, then predict it
    task automatic send_request(input logic mode, input logic [7:0] code);
        if (source_gaps_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= code;
        do @(posedge aclk); while (!s_axis_tready);
        predict_request(mode, code);
    endtask

    task automatic send_read();
        send_request(sc2a_pkg::MODE_READ, 8'($urandom));
    endtask

    task automatic send_key(input logic [7:0] code);
        send_request(sc2a_pkg::MODE_SCANCODE, code);
    endtask

    // Drop valid and wait until every read result has come back
    task automatic source_idle_and_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_reads.size() != 0) @(posedge aclk);
    endtask

    // Edge codes, shift handling, key releases, unmapped keys and empty reads
    task automatic test_directed_cases();
        send_read();
        send_key(8'h00);
        send_key(8'h1E);
        send_key(sc2a_pkg::SC_LSHIFT_MAKE);
        send_key(8'h1E);
        send_key(8'h9E);
        send_key(8'h02);
        send_key(sc2a_pkg::SC_LSHIFT_BREAK);
        send_key(8'h02);
        send_key(sc2a_pkg::SC_RSHIFT_MAKE);
        send_key(8'h35);
        send_key(sc2a_pkg::SC_RSHIFT_BREAK);
        send_key(8'h39);
        send_key(8'h3A);
        send_key(8'h3B);
        send_key(8'h7F);
        send_key(8'h80);
        send_key(8'hFF);
        send_key(8'h1D);
        send_key(8'h01);
        repeat (5) send_read();
        source_idle_and_drain();
    endtask

    // Typing with shifted words, releases, noise and reads mixed in
    task automatic test_random_typing(input int n_steps, input int read_pct);
        int r;
        for (int i = 0; i < n_steps; i++) begin
            r = $urandom_range(0, 99);
            if (r < read_pct) begin
                send_read();
            end else if (r < read_pct + 8) begin
                send_key($urandom_range(0, 1) ? sc2a_pkg::SC_LSHIFT_MAKE
                                              : sc2a_pkg::SC_RSHIFT_MAKE);
                repeat ($urandom_range(1, 4)) send_key(8'($urandom_range(0, KEY_COUNT - 1)));
                send_key($urandom_range(0, 1) ? sc2a_pkg::SC_LSHIFT_BREAK
                                              : sc2a_pkg::SC_RSHIFT_BREAK);
            end else if (r < read_pct + 16) begin
                send_key(8'h80 | 8'($urandom_range(0, KEY_COUNT - 1)));
            end else if (r < read_pct + 20) begin
                send_key(8'($urandom_range(0, 255)));
            end else begin
                send_key(8'($urandom_range(0, KEY_COUNT - 1)));
            end
        end
        source_idle_and_drain();
    endtask

    // Type until the FIFO is full and past it, then read it empty and beyond
    task automatic test_fill_and_overflow();
        logic [7:0] code;
        while (typed_chars.size() < CHAR_SLOTS) begin
            if ($urandom_range(0, 15) == 0) begin
                send_key(shift_down ? sc2a_pkg::SC_LSHIFT_BREAK : sc2a_pkg::SC_RSHIFT_MAKE);
            end
            do code = 8'($urandom_range(0, KEY_COUNT - 1)); while (BASE_KEYS[code] == '0);
            send_key(code);
        end
        repeat (6) begin
            do code = 8'($urandom_range(0, KEY_COUNT - 1)); while (BASE_KEYS[code] == '0);
            send_key(code);
        end
        send_key(sc2a_pkg::SC_RSHIFT_BREAK);
        while (typed_chars.size() != 0) send_read();
        repeat (2) send_read();
        source_idle_and_drain();
    endtask

    // Stall the result side for a long stretch while requests keep coming
    task automatic test_output_backpressure();
        source_gaps_on = 1'b0;
        repeat (10) send_key(8'($urandom_range(2, 13)));
        hold_off_cycles = 300;
        repeat (40) begin
            if ($urandom_range(0, 1)) send_read();
            else send_key(8'($urandom_range(0, KEY_COUNT - 1)));
        end
        source_idle_and_drain();
        source_gaps_on = 1'b1;
    endtask

    // Finish at full rate with no idling on either side
    task automatic test_full_rate();
        source_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
        test_random_typing(110, 30);
    endtask

    // Run the tests in turn, then let the pipeline settle and report
    initial begin
        wait (aresetn === 1'b1);
        @(posedge aclk);
        test_directed_cases();
        test_random_typing(280, 35);
        test_fill_and_overflow();
        test_output_backpressure();
        test_full_rate();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_reads.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    // Result side: random stall bursts, plus one long hold-off on request
    initial begin : drive_sink
        int stall_len;
        forever begin
            @(posedge aclk);
            if (hold_off_cycles > 0) begin
                m_axis_tready <= 1'b0;
                while (hold_off_cycles > 0) begin
                    @(posedge aclk);
                    hold_off_cycles--;
                end
                m_axis_tready <= 1'b1;
            end else if (sink_stalls_on && aresetn && $urandom_range(0, 5) == 0) begin
                stall_len = $urandom_range(1, 14);
                m_axis_tready <= 1'b0;
                repeat (stall_len) @(posedge aclk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Compare each read result with the oldest prediction
    always @(posedge aclk) begin : check_results
        char_result_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_reads.size() == 0) begin
                note_failure("result with no read pending", '0, m_axis_tuser, m_axis_tdata);
            end else begin
                want = pending_reads.pop_front();
                if (m_axis_tuser !== want.valid || m_axis_tdata !== {1'b0, want.code}) begin
                    note_failure("read result mismatch", want, m_axis_tuser, m_axis_tdata);
                end
            end
        end
    end

    // End the run when nothing moves on either side for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_top failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule
